/* sv/ute_pkg.sv */
// Shared constants and types of the UTF-16 to UTF-8 key encoder.
`default_nettype none

package ute_pkg;

  localparam logic [15:0] SurrHighFirst = 16'hD800;
  localparam logic [15:0] SurrHighLast  = 16'hDBFF;
  localparam logic [15:0] SurrLowFirst  = 16'hDC00;
  localparam logic [15:0] SurrLowLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase      = 21'h10000;
  localparam logic [15:0] OneByteLimit  = 16'h0080;
  localparam logic [15:0] TwoByteLimit  = 16'h0800;

  localparam logic [7:0] ContPrefix  = 8'h80;
  localparam logic [7:0] Lead2Prefix = 8'hC0;
  localparam logic [7:0] Lead3Prefix = 8'hE0;
  localparam logic [7:0] Lead4Prefix = 8'hF0;
  localparam logic [5:0] ContMask    = 6'h3F;

  // A single code unit causes at most seven bytes.
  localparam int unsigned MaxBytes = 7;
  localparam int unsigned CntW     = 3;

  // Default number of entries in the job queue.
  localparam int unsigned QueueDepthDef = 2;

  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    cnt_t                     cnt;
    logic                     tail_done;
    logic                     tail_bad;
  } job_t;

endpackage

`default_nettype wire

/* sv/ute_if.sv */
// Channel interfaces: code units in, UTF-8 bytes out.
`default_nettype none

interface ute_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface ute_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       key_done;
  logic       bad_key;

  modport source (output valid, output out_byte, output last_of_run, output key_done,
                  output bad_key, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input key_done,
                  input bad_key, output ready);
endinterface

`default_nettype wire

/* sv/ute_front.sv */
// Front end: takes code units, tracks a held high surrogate and builds byte jobs.
`default_nettype none

module ute_front
  import ute_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ute_in_if.sink    in_i,
  input  wire logic full_i,
  output logic      push_o,
  output job_t      job_o
);

  logic        held_valid_q, held_valid_d;
  logic [9:0]  held_high_q, held_high_d;
  logic        acc;
  logic        is_low, is_high, is_zero, pair;
  logic [15:0] unit;
  logic [15:0] held_cp;
  logic [20:0] cp4;
  cnt_t        nb;

  assign unit       = in_i.code_unit;
  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;

  assign is_low  = (unit >= SurrLowFirst) && (unit <= SurrLowLast);
  assign is_high = (unit >= SurrHighFirst) && (unit <= SurrHighLast);
  assign is_zero = (unit == '0);
  assign pair    = held_valid_q && is_low;

  assign held_cp = SurrHighFirst | {6'b0, held_high_q};
  assign cp4     = SuppBase + {1'b0, held_high_q, unit[9:0]};

  always_comb begin
    job_o       = '0;
    nb          = '0;
    held_valid_d = held_valid_q;
    held_high_d  = held_high_q;
    if (pair) begin
      job_o.bytes[0] = Lead4Prefix | {5'b0, cp4[20:18]};
      job_o.bytes[1] = ContPrefix | {2'b0, cp4[17:12]};
      job_o.bytes[2] = ContPrefix | {2'b0, cp4[11:6]};
      job_o.bytes[3] = ContPrefix | {2'b0, cp4[5:0]};
      nb = cnt_t'(4);
      if (in_i.last_unit) begin
        job_o.bytes[nb] = '0;
        job_o.tail_done = 1'b1;
        nb = nb + cnt_t'(1);
      end
    end else begin
      // A held high surrogate that is not completed goes out alone.
      if (held_valid_q) begin
        job_o.bytes[0] = Lead3Prefix | {4'b0, held_cp[15:12]};
        job_o.bytes[1] = ContPrefix | {2'b0, held_cp[11:6]};
        job_o.bytes[2] = ContPrefix | {2'b0, held_cp[5:0]};
        nb = cnt_t'(3);
      end
      if (is_zero) begin
        job_o.bytes[nb] = '0;
        job_o.tail_bad  = 1'b1;
        nb = nb + cnt_t'(1);
      end else if (!(is_high && !in_i.last_unit)) begin
        if (unit < OneByteLimit) begin
          job_o.bytes[nb] = {1'b0, unit[6:0]};
          nb = nb + cnt_t'(1);
        end else if (unit < TwoByteLimit) begin
          job_o.bytes[nb] = Lead2Prefix | {3'b0, unit[10:6]};
          nb = nb + cnt_t'(1);
          job_o.bytes[nb] = ContPrefix | {2'b0, unit[5:0] & ContMask};
          nb = nb + cnt_t'(1);
        end else begin
          job_o.bytes[nb] = Lead3Prefix | {4'b0, unit[15:12]};
          nb = nb + cnt_t'(1);
          job_o.bytes[nb] = ContPrefix | {2'b0, unit[11:6]};
          nb = nb + cnt_t'(1);
          job_o.bytes[nb] = ContPrefix | {2'b0, unit[5:0] & ContMask};
          nb = nb + cnt_t'(1);
        end
        if (in_i.last_unit) begin
          job_o.bytes[nb] = '0;
          job_o.tail_done = 1'b1;
          nb = nb + cnt_t'(1);
        end
      end
    end
    job_o.cnt = nb;
    if (acc) begin
      held_valid_d = !pair && is_high && !in_i.last_unit;
      held_high_d  = unit[9:0];
    end
  end

  assign push_o = acc && (nb != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_high_q  <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_high_q  <= held_high_d;
    end
  end

  a_hold_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && is_high && !in_i.last_unit |=> held_valid_q)
    else $error("high surrogate not held");

  a_clear_on_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (is_zero || in_i.last_unit) |=> !held_valid_q)
    else $error("surrogate still held after end of key");

  a_tail_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !(job_o.tail_done && job_o.tail_bad))
    else $error("job marked both done and bad");

endmodule

`default_nettype wire

/* sv/ute_fifo.sv */
// Small job queue between the front end and the byte sequencer.
`default_nettype none

module ute_fifo
  import ute_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      wr_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      rd_data_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  job_t             mem_q [Depth];
  logic [IdxW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o    = (fill_q == FillW'(Depth));
  assign valid_o   = (fill_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + IdxW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + IdxW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FillW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FillW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/ute_back.sv */
// Back end: walks each job one byte per cycle into the output register while out_o is not stalled.
`default_nettype none

module ute_back
  import ute_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  ute_out_if.source out_o
);

  job_t       job_q;
  logic       job_valid_q;
  cnt_t       idx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       last_q, done_q, bad_q;
  logic       out_load, emit, finishing;

  assign out_load  = !out_valid_q || out_o.ready;
  assign emit      = job_valid_q && out_load;
  assign finishing = emit && (idx_q == job_q.cnt - cnt_t'(1));
  assign pop_o     = job_valid_i && (!job_valid_q || finishing);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        job_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (finishing) begin
        job_valid_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + cnt_t'(1);
      end
      if (out_load) begin
        out_valid_q <= job_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_byte_q <= job_q.bytes[idx_q];
      last_q     <= finishing;
      done_q     <= finishing && job_q.tail_done;
      bad_q      <= finishing && job_q.tail_bad;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.last_of_run = last_q;
  assign out_o.key_done    = done_q;
  assign out_o.bad_key     = bad_q;

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (idx_q < job_q.cnt))
    else $error("byte index past end of job");

  a_tail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (done_q || bad_q) |-> (out_byte_q == '0) && last_q)
    else $error("terminator or error result is not a final zero byte");

  a_job_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finishing && !pop_o |=> !job_valid_q)
    else $error("job still active after its last byte");

endmodule

`default_nettype wire

/* sv/utf16_to_utf8_key_encoder.sv */
// Top level of the UTF-16 to UTF-8 key encoder.
// The in_i channel takes one UTF-16 code unit per transfer, with last_unit set on
// the final unit of a key. The out_o channel gives one UTF-8 byte per transfer;
// last_of_run marks the final byte caused by an input unit, key_done marks the
// zero terminator after the last unit, and bad_key marks the zero result that a
// zero code unit causes. Unless last, a high surrogate waits for the next unit.
// The first byte of a unit passes the job queue, the sequencer's job register
// and the output register. The sequencer sends one byte per cycle while the
// receiver is ready. A unit gives one byte for ASCII, two or three for others,
// four for a pair, up to seven when a held surrogate is flushed and a terminator
// follows. The front end takes a unit each cycle while the job queue has room.
// Reset clears the held surrogate, the job queue and the output register.
// When the receiver stalls, the output register holds its byte, the sequencer
// and queue fill up, and in_i.ready drops once the queue is full.
`default_nettype none

module utf16_to_utf8_key_encoder
  import ute_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ute_in_if.sink    in_i,
  ute_out_if.source out_o
);

  logic push, full, pop, head_valid;
  job_t wr_job, head_job;

  ute_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (wr_job)
  );

  ute_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (wr_job),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (head_valid),
    .rd_data_o (head_job)
  );

  ute_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
